[rtl/blir_pkg.sv]
package blir_pkg;

  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // Operation codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_PREPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_LIST    = 2'd3;

  // Result status codes carried on the output tuser
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

[rtl/blir_ram.sv]
module blir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/bounded_list_insert_remove_unit.sv]
// Bounded ordered list of signed 32-bit values, up to DEPTH entries.
//
// Input channel (s_axis): one beat is one operation. tuser selects append at
// the tail, insert at the head, remove the first equal entry, or list all;
// tdata carries the value (ignored for listing).
// Output channel (m_axis): one beat per result; status on tuser, value, count
// and empty flag on tdata, tlast on the final result of an operation.
//
// The entries live in one RAM used as a ring: head pointer plus count, so
// append and insert are a single write. Steps after an operation is accepted:
//   append / insert : written in S_IDLE; S_RESP then registers the result.
//   remove          : S_SCAN reads entries up to the match, then S_SHIFT
//                     moves each later entry up one slot, then S_RESP
//                     registers the result.
//   list            : one beat per cycle from S_LIST unless m_axis stalls.
// The RAM read port is registered; a new operation is taken only in S_IDLE.
// Reset clears state, head, count and m_valid; entries >= count are never used.
// A stall on m_axis holds the output register; an input beat is still taken
// while a finished result waits, and work stops only when the next result
// has nowhere to go.
module bounded_list_insert_remove_unit
  import blir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VALUE_W-1:0]  s_axis_tdata,   // value
  input  logic [OP_W-1:0]     s_axis_tuser,   // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // entry_value, entry_count, is_empty, zero padding
  output logic [((VALUE_W+$clog2(DEPTH+1)+1)+7)/8*8-1:0] m_axis_tdata,
  output logic [STATUS_W-1:0] m_axis_tuser,   // status
  output logic                m_axis_tlast    // is_last
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH+1);
  localparam int OUT_W = ((VALUE_W+CW+1)+7)/8*8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_LIST  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  // Ring position of list index k; head + k stays below 2*DEPTH.
  function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
                                             input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW+1-PW){1'b0}}, base} + {1'b0, k};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  logic [2:0]          state, state_next;
  logic [PW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       idx, idx_next;
  value_t              val, val_next;
  logic [STATUS_W-1:0] resp_status, resp_status_next;
  value_t              resp_value, resp_value_next;

  logic                m_valid, m_valid_next;
  logic [STATUS_W-1:0] m_status, m_status_next;
  value_t              m_value, m_value_next;
  logic [CW-1:0]       m_count, m_count_next;
  logic                m_empty, m_empty_next;
  logic                m_last, m_last_next;

  logic                out_free;
  logic                full;
  logic [CW-1:0]       idx_inc;
  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  value_t              wr_data;
  logic [PW-1:0]       rd_addr;
  value_t              rd_data;

  blir_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free      = !m_valid || m_axis_tready;
  assign full          = (count == CW'(DEPTH));
  assign idx_inc       = idx + 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = OUT_W'({m_empty, m_count, m_value});
  assign m_axis_tuser  = m_status;
  assign m_axis_tlast  = m_last;

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    idx_next         = idx;
    val_next         = val;
    resp_status_next = resp_status;
    resp_value_next  = resp_value;
    m_valid_next     = m_valid && !m_axis_tready;
    m_status_next    = m_status;
    m_value_next     = m_value;
    m_count_next     = m_count;
    m_empty_next     = m_empty;
    m_last_next      = m_last;
    rd_addr          = head;
    wr_en            = 1'b0;
    wr_addr          = head;
    wr_data          = val;

    unique case (state)
      S_IDLE: begin
        // Head is read every idle cycle so a scan or listing starts primed.
        if (s_axis_tvalid) begin
          val_next        = s_axis_tdata;
          idx_next        = '0;
          resp_value_next = '0;
          unique case (s_axis_tuser)
            OP_APPEND: begin
              state_next = S_RESP;
              if (full) begin
                resp_status_next = ST_FULL;
              end else begin
                wr_en            = 1'b1;
                wr_addr          = ring_pos(head, count);
                wr_data          = s_axis_tdata;
                count_next       = count + 1'b1;
                resp_status_next = ST_DONE;
              end
            end
            OP_PREPEND: begin
              state_next = S_RESP;
              if (full) begin
                resp_status_next = ST_FULL;
              end else begin
                head_next        = (head == '0) ? PW'(DEPTH-1) : head - 1'b1;
                wr_en            = 1'b1;
                wr_addr          = head_next;
                wr_data          = s_axis_tdata;
                count_next       = count + 1'b1;
                resp_status_next = ST_DONE;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                resp_status_next = ST_MISS;
                state_next       = S_RESP;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                state_next = S_LIST;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds entry idx; fetch the next one in case the gap closes.
        rd_addr = ring_pos(head, idx_inc);
        if (rd_data == val) begin
          resp_status_next = ST_DONE;
          resp_value_next  = val;
          if (idx_inc == count) begin
            count_next = count - 1'b1;
            state_next = S_RESP;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (idx_inc == count) begin
          resp_status_next = ST_MISS;
          state_next       = S_RESP;
        end else begin
          idx_next = idx_inc;
        end
      end

      S_SHIFT: begin
        // Move entry idx+1 (now on rd_data) up into slot idx.
        rd_addr = ring_pos(head, idx + CW'(2));
        wr_en   = 1'b1;
        wr_addr = ring_pos(head, idx);
        wr_data = rd_data;
        if (idx + CW'(2) == count) begin
          count_next = count - 1'b1;
          state_next = S_RESP;
        end else begin
          idx_next = idx_inc;
        end
      end

      S_LIST: begin
        if (out_free) begin
          m_valid_next  = 1'b1;
          m_status_next = ST_ENTRY;
          m_value_next  = rd_data;
          m_count_next  = count;
          m_empty_next  = 1'b0;
          m_last_next   = (idx_inc == count);
          if (idx_inc == count) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx_inc;
            rd_addr  = ring_pos(head, idx_inc);
          end
        end else begin
          // Re-read the same entry to hold it across the stall.
          rd_addr = ring_pos(head, idx);
        end
      end

      S_RESP: begin
        if (out_free) begin
          m_valid_next  = 1'b1;
          m_status_next = resp_status;
          m_value_next  = resp_value;
          m_count_next  = count;
          m_empty_next  = (count == '0);
          m_last_next   = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      m_valid <= m_valid_next;
    end
    idx         <= idx_next;
    val         <= val_next;
    resp_status <= resp_status_next;
    resp_value  <= resp_value_next;
    m_status    <= m_status_next;
    m_value     <= m_value_next;
    m_count     <= m_count_next;
    m_empty     <= m_empty_next;
    m_last      <= m_last_next;
  end

endmodule

[rtl/blir_checker.sv]
module blir_checker
  import blir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [((VALUE_W+$clog2(DEPTH+1)+1)+7)/8*8-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser,
  input logic                m_axis_tlast
);

  localparam int CW = $clog2(DEPTH+1);

  logic [VALUE_W-1:0] out_value;
  logic [CW-1:0]      out_count;
  logic               out_empty;

  assign out_value = m_axis_tdata[VALUE_W-1:0];
  assign out_count = m_axis_tdata[VALUE_W +: CW];
  assign out_empty = m_axis_tdata[VALUE_W+CW];

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Empty flag agrees with the count, and the count never exceeds the depth
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_empty == (out_count == '0)) && (out_count <= CW'(DEPTH)))
    else $error("empty flag or count inconsistent");

  // A listed entry comes from a non-empty list
  a_entry: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_ENTRY) |-> (out_count != '0))
    else $error("listed entry from empty list");

  // Every result other than a listed entry closes its operation
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_ENTRY) |-> m_axis_tlast)
    else $error("single result without last");

  // Rejected, missed and empty results carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ((m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_MISS) ||
                      (m_axis_tuser == ST_EMPTY)) |-> (out_value == '0))
    else $error("non-zero value on a valueless result");

endmodule

bind bounded_list_insert_remove_unit blir_checker #(.DEPTH(DEPTH)) u_blir_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
